// ===== rtl/ccov_pkg.sv =====
// ----------------------------------------------------------------------------
// ccov_pkg
// Widths, types and codes shared by the capsule overlap pipeline.
// ----------------------------------------------------------------------------
package ccov_pkg;

   localparam int COORD_BITS      = 20;
   localparam int PARAM_FRAC_BITS = 16;

   // request and response field widths
   localparam int PT_W  = 3 * COORD_BITS;
   localparam int RAD_W = 19;
   localparam int DSQ_W = 48;

   // segment deltas and dot products
   localparam int D_W     = COORD_BITS + 1;
   localparam int MAG_W   = 2 * D_W;
   localparam int DOT_W   = MAG_W + 1;
   localparam int SPL_W   = MAG_W / 2;
   localparam int SPH_W   = MAG_W - SPL_W;
   localparam int PP_W    = MAG_W + SPH_W;
   localparam int PROD_W  = 2 * MAG_W;
   localparam int NUM_W   = PROD_W + 2;
   localparam int REM_W   = PROD_W + 1;

   // segment parameters, Q1.P with one integer bit
   localparam int P_W = PARAM_FRAC_BITS;
   localparam int Q_W = P_W + 1;
   localparam logic [Q_W-1:0] P_ONE = {1'b1, {P_W{1'b0}}};

   localparam int BS_W  = DOT_W + Q_W + 1;
   localparam int TN_W  = BS_W + 1;
   localparam int ESC_W = MAG_W + P_W;

   // closest point offsets and distance
   localparam int PD_W   = D_W + Q_W + 1;
   localparam int DK_W   = D_W + P_W + 2;
   localparam int MK_W   = DK_W - 1;
   localparam int SQL_W  = MK_W / 2;
   localparam int SQH_W  = MK_W - SQL_W;
   localparam int SQP_W  = MK_W + SQH_W;
   localparam int SQ_W   = 2 * MK_W;
   localparam int DIST_W = SQ_W + 2;
   localparam int RS_W   = RAD_W + 1;
   localparam int LIM_W  = 2 * RS_W + 2 * P_W;
   localparam int CMP_W  = (LIM_W > DIST_W) ? LIM_W : DIST_W;
   localparam int SAT_W  = (DIST_W + 1 > DSQ_W + 1) ? DIST_W + 1 : DSQ_W + 1;

   // which parameter a quotient lands in
   typedef enum logic [1:0] {
      TGT_NONE,
      TGT_S,
      TGT_T
   } tgt_type;

   typedef struct packed {
      logic [2:0][D_W-1:0]       d1;
      logic [2:0][D_W-1:0]       d2;
      logic [2:0][D_W-1:0]       r;
      logic [MAG_W-1:0]          a;
      logic [MAG_W-1:0]          e;
      logic signed [DOT_W-1:0]   b;
      logic signed [DOT_W-1:0]   c;
      logic signed [DOT_W-1:0]   f;
      logic [LIM_W-1:0]          lim;
      logic                      az;
      logic                      ez;
      logic [Q_W-1:0]            s;
      logic [Q_W-1:0]            t;
      tgt_type                   tgt;
   } ctx_type;

   typedef struct packed {
      logic                      valid;
      logic signed [NUM_W-1:0]   num;
      logic [PROD_W-1:0]         den;
      ctx_type                   ctx;
   } div_req_type;

   typedef struct packed {
      logic                      valid;
      logic [Q_W-1:0]            q;
      ctx_type                   ctx;
   } div_rsp_type;

endpackage

// ===== rtl/ccov_req_if.sv =====
// ----------------------------------------------------------------------------
// ccov_req_if
// Request channel: two capsules per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccov_req_if;
   import ccov_pkg::*;

   logic             valid;
   logic             ready;
   logic [PT_W-1:0]  a_start;
   logic [PT_W-1:0]  a_end;
   logic [PT_W-1:0]  b_start;
   logic [PT_W-1:0]  b_end;
   logic [RAD_W-1:0] a_radius;
   logic [RAD_W-1:0] b_radius;

   modport source (output valid, a_start, a_end, b_start, b_end, a_radius, b_radius,
                   input ready);
   modport sink   (input valid, a_start, a_end, b_start, b_end, a_radius, b_radius,
                   output ready);
endinterface

// ===== rtl/ccov_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ccov_rsp_if
// Response channel: hit flag and squared distance, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccov_rsp_if;
   import ccov_pkg::*;

   logic             valid;
   logic             ready;
   logic             hit;
   logic [DSQ_W-1:0] distance_sq;

   modport source (output valid, hit, distance_sq, input ready);
   modport sink   (input valid, hit, distance_sq, output ready);
endinterface

// ===== rtl/ccov_div.sv =====
// ----------------------------------------------------------------------------
// ccov_div
// Pipelined clamped divider: q = clamp(num/den, 0, 1) in Q1.P, truncated.
// One range check stage, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module ccov_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  ccov_pkg::div_req_type req_in,
   output ccov_pkg::div_rsp_type rsp_out
);
   import ccov_pkg::*;

   logic              v_ff    [0:P_W];
   logic [REM_W-1:0]  rem_ff  [0:P_W];
   logic [P_W-1:0]    q_ff    [0:P_W];
   logic [PROD_W-1:0] den_ff  [0:P_W];
   logic              zero_ff [0:P_W];
   logic              one_ff  [0:P_W];
   ctx_type           ctx_ff  [0:P_W];

   logic zero_in, one_in;

   always_comb begin
      zero_in = req_in.num[NUM_W-1] || (req_in.num == '0);
      one_in  = !req_in.num[NUM_W-1] && ($unsigned(req_in.num) >= NUM_W'(req_in.den));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= REM_W'(req_in.num[PROD_W-1:0]);
         q_ff[0]    <= '0;
         den_ff[0]  <= req_in.den;
         zero_ff[0] <= zero_in;
         one_ff[0]  <= one_in;
         ctx_ff[0]  <= req_in.ctx;
      end
   end

   for (genvar i = 0; i < P_W; i++) begin : g_step
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] remn;
      logic             ge;

      always_comb begin
         rem2 = {rem_ff[i][REM_W-2:0], 1'b0};
         ge   = rem2 >= REM_W'(den_ff[i]);
         remn = ge ? rem2 - REM_W'(den_ff[i]) : rem2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i+1]  <= remn;
            q_ff[i+1]    <= {q_ff[i][P_W-2:0], ge};
            den_ff[i+1]  <= den_ff[i];
            zero_ff[i+1] <= zero_ff[i];
            one_ff[i+1]  <= one_ff[i];
            ctx_ff[i+1]  <= ctx_ff[i];
         end
      end
   end

   always_comb begin
      rsp_out.valid = v_ff[P_W];
      rsp_out.ctx   = ctx_ff[P_W];
      if (zero_ff[P_W]) begin
         rsp_out.q = '0;
      end else if (one_ff[P_W]) begin
         rsp_out.q = P_ONE;
      end else begin
         rsp_out.q = {1'b0, q_ff[P_W]};
      end
   end

endmodule

// ===== rtl/capsule_capsule_overlap_top.sv =====
// ----------------------------------------------------------------------------
// capsule_capsule_overlap_top
// Capsule against capsule overlap test with squared segment distance.
// ----------------------------------------------------------------------------
// Usage:
//   req carries two capsules (segment end points as packed signed x,y,z and a
//   radius each). rsp returns hit (squared distance within squared radius sum)
//   and the squared shortest segment distance, rounded and saturating.
//   One request is taken per cycle while rsp is not holding the pipe; requests are independent.
//   The pipe has six stages of dot products and wide products, two clamped
//   dividers of one quotient bit per stage plus a range check each, four
//   stages for the t numerator, one to apply the result and six for
//   distance, compare and output.
//   Every stage advances together; when rsp is held off with a result waiting
//   the whole pipe holds and req.ready drops, nothing is lost or repeated.
//   Reset clears the valid bits only; the block is ready the cycle after.
// ----------------------------------------------------------------------------
module capsule_capsule_overlap_top (
   input logic         clock,
   input logic         reset,
   ccov_req_if.sink    req,
   ccov_rsp_if.source  rsp
);
   import ccov_pkg::*;

   logic adv;
   logic out_v_ff;

   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   // ---------------- stage 1: deltas
   logic v1_ff;
   ctx_type ctx1_in, ctx1_ff;
   logic [RS_W-1:0] rs_in, rs_ff;

   always_comb begin
      ctx1_in = '0;
      for (int k = 0; k < 3; k++) begin
         ctx1_in.d1[k] = D_W'($signed(req.a_end[k*COORD_BITS +: COORD_BITS]))
                       - D_W'($signed(req.a_start[k*COORD_BITS +: COORD_BITS]));
         ctx1_in.d2[k] = D_W'($signed(req.b_end[k*COORD_BITS +: COORD_BITS]))
                       - D_W'($signed(req.b_start[k*COORD_BITS +: COORD_BITS]));
         ctx1_in.r[k]  = D_W'($signed(req.a_start[k*COORD_BITS +: COORD_BITS]))
                       - D_W'($signed(req.b_start[k*COORD_BITS +: COORD_BITS]));
      end
      rs_in = RS_W'(req.a_radius) + RS_W'(req.b_radius);
   end

   // ---------------- stage 2: component products
   logic v2_ff;
   ctx_type ctx2_in, ctx2_ff;
   logic [2:0][MAG_W-1:0] aa_in, ee_in, bb_in, cc_in, ff_in;
   logic [2:0][MAG_W-1:0] aa_ff, ee_ff, bb_ff, cc_ff, ff_ff;
   logic [2*RS_W-1:0] rsq;

   always_comb begin
      ctx2_in = ctx1_ff;
      for (int k = 0; k < 3; k++) begin
         aa_in[k] = $signed(ctx1_ff.d1[k]) * $signed(ctx1_ff.d1[k]);
         ee_in[k] = $signed(ctx1_ff.d2[k]) * $signed(ctx1_ff.d2[k]);
         bb_in[k] = $signed(ctx1_ff.d1[k]) * $signed(ctx1_ff.d2[k]);
         cc_in[k] = $signed(ctx1_ff.d1[k]) * $signed(ctx1_ff.r[k]);
         ff_in[k] = $signed(ctx1_ff.d2[k]) * $signed(ctx1_ff.r[k]);
      end
      rsq = {{RS_W{1'b0}}, rs_ff} * {{RS_W{1'b0}}, rs_ff};
      ctx2_in.lim = {rsq, {(2*P_W){1'b0}}};
   end

   // ---------------- stage 3: dot products
   logic v3_ff;
   ctx_type ctx3_in, ctx3_ff;
   logic signed [DOT_W-1:0] asum, esum;

   always_comb begin
      ctx3_in = ctx2_ff;
      asum = DOT_W'($signed(aa_ff[0])) + DOT_W'($signed(aa_ff[1]))
           + DOT_W'($signed(aa_ff[2]));
      esum = DOT_W'($signed(ee_ff[0])) + DOT_W'($signed(ee_ff[1]))
           + DOT_W'($signed(ee_ff[2]));
      ctx3_in.a = asum[MAG_W-1:0];
      ctx3_in.e = esum[MAG_W-1:0];
      ctx3_in.b = DOT_W'($signed(bb_ff[0])) + DOT_W'($signed(bb_ff[1]))
                + DOT_W'($signed(bb_ff[2]));
      ctx3_in.c = DOT_W'($signed(cc_ff[0])) + DOT_W'($signed(cc_ff[1]))
                + DOT_W'($signed(cc_ff[2]));
      ctx3_in.f = DOT_W'($signed(ff_ff[0])) + DOT_W'($signed(ff_ff[1]))
                + DOT_W'($signed(ff_ff[2]));
   end

   // ---------------- stage 4: split partial products for ae, bb, bf, ce
   logic v4_ff;
   ctx_type ctx4_in, ctx4_ff;
   logic signed [DOT_W-1:0] nb, nc, nf;
   logic [3:0][MAG_W-1:0] mx, my;
   logic [3:0][PP_W-1:0] pl_in, ph_in, pl_ff, ph_ff;
   logic bfn_in, cen_in, bfn4_ff, cen4_ff;

   always_comb begin
      ctx4_in    = ctx3_ff;
      ctx4_in.az = (ctx3_ff.a == '0);
      ctx4_in.ez = (ctx3_ff.e == '0);
      nb = ctx3_ff.b[DOT_W-1] ? -ctx3_ff.b : ctx3_ff.b;
      nc = ctx3_ff.c[DOT_W-1] ? -ctx3_ff.c : ctx3_ff.c;
      nf = ctx3_ff.f[DOT_W-1] ? -ctx3_ff.f : ctx3_ff.f;
      mx[0] = ctx3_ff.a;        my[0] = ctx3_ff.e;
      mx[1] = nb[MAG_W-1:0];    my[1] = nb[MAG_W-1:0];
      mx[2] = nb[MAG_W-1:0];    my[2] = nf[MAG_W-1:0];
      mx[3] = nc[MAG_W-1:0];    my[3] = ctx3_ff.e;
      for (int i = 0; i < 4; i++) begin
         pl_in[i] = PP_W'(mx[i]) * PP_W'(my[i][SPL_W-1:0]);
         ph_in[i] = PP_W'(mx[i]) * PP_W'(my[i][MAG_W-1:SPL_W]);
      end
      bfn_in = ctx3_ff.b[DOT_W-1] ^ ctx3_ff.f[DOT_W-1];
      cen_in = ctx3_ff.c[DOT_W-1];
   end

   // ---------------- stage 5: recombine wide products
   logic v5_ff;
   logic [3:0][PROD_W-1:0] prod_in, prod_ff;
   ctx_type ctx5_ff;
   logic bfn5_ff, cen5_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = PROD_W'(pl_ff[i]) + (PROD_W'(ph_ff[i]) << SPL_W);
      end
   end

   // ---------------- stage 6: first divider request
   logic v6_ff;
   logic [PROD_W-1:0] denom;
   logic signed [NUM_W-1:0] sbf, sce, numg;
   logic signed [NUM_W-1:0] num6_in, num6_ff;
   logic [PROD_W-1:0] den6_in, den6_ff;
   ctx_type ctx6_in, ctx6_ff;

   always_comb begin
      ctx6_in = ctx5_ff;
      denom = prod_ff[0] - prod_ff[1];
      sbf   = bfn5_ff ? -NUM_W'(prod_ff[2]) : NUM_W'(prod_ff[2]);
      sce   = cen5_ff ? -NUM_W'(prod_ff[3]) : NUM_W'(prod_ff[3]);
      numg  = sbf - sce;
      num6_in = '0;
      den6_in = PROD_W'(1);
      ctx6_in.tgt = TGT_NONE;
      if (ctx5_ff.az && ctx5_ff.ez) begin
         ctx6_in.tgt = TGT_NONE;
      end else if (ctx5_ff.az) begin
         num6_in = NUM_W'(ctx5_ff.f);
         den6_in = PROD_W'(ctx5_ff.e);
         ctx6_in.tgt = TGT_T;
      end else if (ctx5_ff.ez) begin
         num6_in = -NUM_W'(ctx5_ff.c);
         den6_in = PROD_W'(ctx5_ff.a);
         ctx6_in.tgt = TGT_S;
      end else begin
         ctx6_in.tgt = TGT_S;
         // parallel segments keep s at zero
         if (denom != '0) begin
            num6_in = numg;
            den6_in = denom;
         end
      end
   end

   div_req_type div1_req;
   div_rsp_type div1_rsp;

   assign div1_req = '{valid: v6_ff, num: num6_ff, den: den6_ff, ctx: ctx6_ff};

   ccov_div u_div1 (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .req_in  (div1_req),
      .rsp_out (div1_rsp)
   );

   // ---------------- F1: apply first quotient
   logic vf1_ff;
   ctx_type cf1_in, cf1_ff;

   always_comb begin
      cf1_in = div1_rsp.ctx;
      case (div1_rsp.ctx.tgt)
         TGT_S:   cf1_in.s = div1_rsp.q;
         TGT_T:   cf1_in.t = div1_rsp.q;
         default: cf1_in.s = div1_rsp.ctx.s;
      endcase
   end

   // ---------------- F2: b*s
   logic vf2_ff;
   ctx_type cf2_ff;
   logic signed [BS_W-1:0] bs_in, bs_ff;

   assign bs_in = cf1_ff.b * $signed({1'b0, cf1_ff.s});

   // ---------------- F3: t numerator and scaled e
   logic vf3_ff;
   ctx_type cf3_ff;
   logic signed [TN_W-1:0] tn_in, tn_ff;
   logic [ESC_W-1:0] esc_in, esc_ff;

   always_comb begin
      tn_in  = TN_W'(bs_ff) + (TN_W'(cf2_ff.f) <<< P_W);
      esc_in = {cf2_ff.e, {P_W{1'b0}}};
   end

   // ---------------- F4: second divider request
   logic vf4_ff;
   logic signed [NUM_W-1:0] num2_in, num2_ff;
   logic [PROD_W-1:0] den2_in, den2_ff;
   ctx_type cf4_in, cf4_ff;

   always_comb begin
      cf4_in = cf3_ff;
      num2_in = '0;
      den2_in = PROD_W'(1);
      cf4_in.tgt = TGT_NONE;
      if (!cf3_ff.az && !cf3_ff.ez) begin
         if (tn_ff[TN_W-1]) begin
            cf4_in.t   = '0;
            num2_in    = -NUM_W'(cf3_ff.c);
            den2_in    = PROD_W'(cf3_ff.a);
            cf4_in.tgt = TGT_S;
         end else if (tn_ff > $signed(TN_W'(esc_ff))) begin
            cf4_in.t   = P_ONE;
            num2_in    = NUM_W'(cf3_ff.b) - NUM_W'(cf3_ff.c);
            den2_in    = PROD_W'(cf3_ff.a);
            cf4_in.tgt = TGT_S;
         end else begin
            num2_in    = NUM_W'(tn_ff);
            den2_in    = PROD_W'(esc_ff);
            cf4_in.tgt = TGT_T;
         end
      end
   end

   div_req_type div2_req;
   div_rsp_type div2_rsp;

   assign div2_req = '{valid: vf4_ff, num: num2_ff, den: den2_ff, ctx: cf4_ff};

   ccov_div u_div2 (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .req_in  (div2_req),
      .rsp_out (div2_rsp)
   );

   // ---------------- G1: apply second quotient
   logic vg1_ff;
   ctx_type cg1_in, cg1_ff;

   always_comb begin
      cg1_in = div2_rsp.ctx;
      case (div2_rsp.ctx.tgt)
         TGT_S:   cg1_in.s = div2_rsp.q;
         TGT_T:   cg1_in.t = div2_rsp.q;
         default: cg1_in.s = div2_rsp.ctx.s;
      endcase
   end

   // ---------------- H1: d1*s, d2*t
   logic vh1_ff;
   ctx_type ch1_ff;
   logic [2:0][PD_W-1:0] pd1_in, pd2_in, pd1_ff, pd2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pd1_in[k] = $signed(cg1_ff.d1[k]) * $signed({1'b0, cg1_ff.s});
         pd2_in[k] = $signed(cg1_ff.d2[k]) * $signed({1'b0, cg1_ff.t});
      end
   end

   // ---------------- H2: closest point offset
   logic vh2_ff;
   ctx_type ch2_ff;
   logic [2:0][DK_W-1:0] dk_in, dk_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dk_in[k] = (DK_W'($signed(ch1_ff.r[k])) <<< P_W)
                  + DK_W'($signed(pd1_ff[k])) - DK_W'($signed(pd2_ff[k]));
      end
   end

   // ---------------- H3: split squares
   logic vh3_ff;
   ctx_type ch3_ff;
   logic [2:0][DK_W-1:0] nk;
   logic [2:0][MK_W-1:0] mk;
   logic [2:0][SQP_W-1:0] sl_in, sh_in, sl_ff, sh_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nk[k] = dk_ff[k][DK_W-1] ? -dk_ff[k] : dk_ff[k];
         mk[k] = nk[k][MK_W-1:0];
         sl_in[k] = SQP_W'(mk[k]) * SQP_W'(mk[k][SQL_W-1:0]);
         sh_in[k] = SQP_W'(mk[k]) * SQP_W'(mk[k][MK_W-1:SQL_W]);
      end
   end

   // ---------------- H4: recombine squares
   logic vh4_ff;
   ctx_type ch4_ff;
   logic [2:0][SQ_W-1:0] sq_in, sq_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = SQ_W'(sl_ff[k]) + (SQ_W'(sh_ff[k]) << SQL_W);
      end
   end

   // ---------------- H5: sum
   logic vh5_ff;
   logic [LIM_W-1:0] lim5_ff;
   logic [DIST_W-1:0] dist_in, dist_ff;

   assign dist_in = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);

   // ---------------- output: compare, round, saturate
   logic hit_in, hit_ff;
   logic [SAT_W-1:0] rnd;
   logic [DSQ_W-1:0] dsq_in, dsq_ff;

   always_comb begin
      hit_in = CMP_W'(dist_ff) <= CMP_W'(lim5_ff);
      rnd    = (SAT_W'(dist_ff) + (SAT_W'(1) << (2*P_W - 1))) >> (2*P_W);
      dsq_in = (|rnd[SAT_W-1:DSQ_W]) ? '1 : rnd[DSQ_W-1:0];
   end

   // ---------------- valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         vf1_ff   <= 1'b0;
         vf2_ff   <= 1'b0;
         vf3_ff   <= 1'b0;
         vf4_ff   <= 1'b0;
         vg1_ff   <= 1'b0;
         vh1_ff   <= 1'b0;
         vh2_ff   <= 1'b0;
         vh3_ff   <= 1'b0;
         vh4_ff   <= 1'b0;
         vh5_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req.valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         v6_ff    <= v5_ff;
         vf1_ff   <= div1_rsp.valid;
         vf2_ff   <= vf1_ff;
         vf3_ff   <= vf2_ff;
         vf4_ff   <= vf3_ff;
         vg1_ff   <= div2_rsp.valid;
         vh1_ff   <= vg1_ff;
         vh2_ff   <= vh1_ff;
         vh3_ff   <= vh2_ff;
         vh4_ff   <= vh3_ff;
         vh5_ff   <= vh4_ff;
         out_v_ff <= vh5_ff;
      end
   end

   // ---------------- payload
   always_ff @(posedge clock) begin
      if (adv) begin
         ctx1_ff <= ctx1_in;
         rs_ff   <= rs_in;
         ctx2_ff <= ctx2_in;
         aa_ff   <= aa_in;
         ee_ff   <= ee_in;
         bb_ff   <= bb_in;
         cc_ff   <= cc_in;
         ff_ff   <= ff_in;
         ctx3_ff <= ctx3_in;
         ctx4_ff <= ctx4_in;
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         bfn4_ff <= bfn_in;
         cen4_ff <= cen_in;
         ctx5_ff <= ctx4_ff;
         prod_ff <= prod_in;
         bfn5_ff <= bfn4_ff;
         cen5_ff <= cen4_ff;
         ctx6_ff <= ctx6_in;
         num6_ff <= num6_in;
         den6_ff <= den6_in;
         cf1_ff  <= cf1_in;
         cf2_ff  <= cf1_ff;
         bs_ff   <= bs_in;
         cf3_ff  <= cf2_ff;
         tn_ff   <= tn_in;
         esc_ff  <= esc_in;
         cf4_ff  <= cf4_in;
         num2_ff <= num2_in;
         den2_ff <= den2_in;
         cg1_ff  <= cg1_in;
         ch1_ff  <= cg1_ff;
         pd1_ff  <= pd1_in;
         pd2_ff  <= pd2_in;
         ch2_ff  <= ch1_ff;
         dk_ff   <= dk_in;
         ch3_ff  <= ch2_ff;
         sl_ff   <= sl_in;
         sh_ff   <= sh_in;
         ch4_ff  <= ch3_ff;
         sq_ff   <= sq_in;
         lim5_ff <= ch4_ff.lim;
         dist_ff <= dist_in;
         hit_ff  <= hit_in;
         dsq_ff  <= dsq_in;
      end
   end

   assign rsp.valid       = out_v_ff;
   assign rsp.hit         = hit_ff;
   assign rsp.distance_sq = dsq_ff;

endmodule
